/* rtl/tpc_pkg.sv */
// Shared types and constants of the TCP port packet classifier.
package tpc_pkg;

  // Ethertypes and protocol codes
  localparam logic [15:0] ETH_VLAN  = 16'h8100;
  localparam logic [15:0] ETH_IPV4  = 16'h0800;
  localparam logic [7:0]  PROTO_TCP = 8'd6;

  // Header positions and lengths, in bytes
  localparam logic [7:0] ETYPE_HI_OFF      = 8'd12;
  localparam logic [7:0] ETYPE_LO_OFF      = 8'd13;
  localparam logic [7:0] VLAN_ETYPE_HI_OFF = 8'd16;
  localparam logic [7:0] VLAN_ETYPE_LO_OFF = 8'd17;
  localparam logic [7:0] ETH_HDR_LEN       = 8'd14;
  localparam logic [7:0] VLAN_HDR_LEN      = 8'd18;
  localparam logic [7:0] MPLS_LABEL_LEN    = 8'd4;
  localparam logic [7:0] IP_PROTO_OFF      = 8'd9;
  localparam logic [7:0] TCP_DPORT_HI_OFF  = 8'd2;
  localparam logic [7:0] TCP_DOFF_OFF      = 8'd12;
  localparam logic [7:0] TCP_MIN_LEN       = 8'd13;
  localparam logic [3:0] IHL_MIN           = 4'd5;

  // Configuration reset values
  localparam logic [7:0]  TRACKED_COLOR_RST  = 8'd1;
  localparam logic [15:0] MPLS_ETHERTYPE_RST = 16'h8847;
  localparam logic [15:0] MATCH_PORT_RST     = 16'd2233;

  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRACKED_COLOR  = 2'd0,
    CFG_MPLS_ETHERTYPE = 2'd1,
    CFG_MATCH_PORT     = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    HDR_ETH    = 2'd0,
    HDR_IP     = 2'd1,
    HDR_REJECT = 2'd2
  } hdr_status_t;

  typedef struct packed {
    logic [7:0]  tracked_color;
    logic [15:0] mpls_ethertype;
    logic [15:0] match_port;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
    logic [7:0] packet_color;
  } beat_t;

  typedef struct packed {
    logic       matched;
    logic [7:0] color_out;
  } verdict_t;

  // Per-frame header state, offset counter kept apart
  typedef struct packed {
    logic [15:0] ether_kind;
    logic        has_vlan;
    logic [7:0]  ip_start;
    logic [7:0]  tcp_start;
    logic [7:0]  tcp_end;
    logic [7:0]  ip_proto;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    hdr_status_t status;
  } hdr_state_t;

  localparam hdr_state_t HDR_CLEAR = '{
    ether_kind: 16'd0, has_vlan: 1'b0, ip_start: ETH_HDR_LEN, tcp_start: 8'd0,
    tcp_end: 8'd0, ip_proto: 8'd0, src_port: 16'd0, dst_port: 16'd0,
    status: HDR_ETH
  };

endpackage

/* rtl/tpc_if.sv */
// Valid/ready channel interfaces for frame bytes and verdicts.
interface tpc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;
  logic [7:0] packet_color;

  modport source (output valid, data_byte, first_byte, last_byte, packet_color,
                  input ready);
  modport sink (input valid, data_byte, first_byte, last_byte, packet_color,
                output ready);
endinterface

interface tpc_out_if;
  logic       valid;
  logic       ready;
  logic       matched;
  logic [7:0] color_out;

  modport source (output valid, matched, color_out, input ready);
  modport sink (input valid, matched, color_out, output ready);
endinterface

/* rtl/tpc_cfg_regs.sv */
// Configuration register file of the classifier.
module tpc_cfg_regs
  import tpc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_TRACKED_COLOR:  cfg_nxt.tracked_color  = cfg_wdata[7:0];
        CFG_MPLS_ETHERTYPE: cfg_nxt.mpls_ethertype = cfg_wdata;
        CFG_MATCH_PORT:     cfg_nxt.match_port     = cfg_wdata;
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tracked_color  <= TRACKED_COLOR_RST;
      cfg_r.mpls_ethertype <= MPLS_ETHERTYPE_RST;
      cfg_r.match_port     <= MATCH_PORT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/tpc_parser.sv */
// Per-byte header parser and frame verdict logic.
module tpc_parser
  import tpc_pkg::*;
#(
  parameter int OFFSET_WIDTH = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step,
  input  beat_t    beat,
  input  cfg_t     cfg,
  output verdict_t verdict
);

  // Compare width: covers the offset and header positions up to 268
  localparam int CW = (OFFSET_WIDTH > 9) ? OFFSET_WIDTH : 9;

  logic [OFFSET_WIDTH-1:0] off_r, off_cur, off_inc, off_nxt;
  hdr_state_t              st_r, st_cur, st_upd, st_nxt;
  logic [CW-1:0]           o_w, len_w, ip_proto_pos, tcp_pos;
  logic [15:0]             kind_low;
  logic [3:0]              ihl;
  logic                    hit;

  always_comb begin
    // Restart the frame on a first-byte beat
    off_cur = beat.first_byte ? '0 : off_r;
    st_cur  = beat.first_byte ? HDR_CLEAR : st_r;
    st_upd  = st_cur;

    o_w          = CW'(off_cur);
    ip_proto_pos = CW'(st_cur.ip_start) + CW'(IP_PROTO_OFF);
    tcp_pos      = CW'(st_cur.tcp_start);
    kind_low     = {st_cur.ether_kind[15:8], beat.data_byte};
    ihl          = beat.data_byte[3:0];

    case (st_cur.status)
      HDR_ETH: begin
        if (o_w == CW'(ETYPE_HI_OFF) || o_w == CW'(VLAN_ETYPE_HI_OFF)) begin
          st_upd.ether_kind = {beat.data_byte, 8'd0};
        end else if (o_w == CW'(ETYPE_LO_OFF) || o_w == CW'(VLAN_ETYPE_LO_OFF)) begin
          st_upd.ether_kind = kind_low;
          if (o_w == CW'(ETYPE_LO_OFF) && kind_low == ETH_VLAN) begin
            st_upd.has_vlan = 1'b1;
          end else if (o_w == CW'(ETYPE_LO_OFF) || st_cur.has_vlan) begin
            // Pick the network layer from the ethertype
            st_upd.ip_start = st_cur.has_vlan ? VLAN_HDR_LEN : ETH_HDR_LEN;
            if (kind_low == cfg.mpls_ethertype) begin
              st_upd.ip_start = st_upd.ip_start + MPLS_LABEL_LEN;
              st_upd.status   = HDR_IP;
            end else if (kind_low == ETH_IPV4) begin
              st_upd.status = HDR_IP;
            end else begin
              st_upd.status = HDR_REJECT;
            end
          end
        end
      end
      HDR_IP: begin
        if (o_w == CW'(st_cur.ip_start)) begin
          if (ihl < IHL_MIN) begin
            st_upd.status = HDR_REJECT;
          end else begin
            st_upd.tcp_start = st_cur.ip_start + 8'({ihl, 2'b00});
          end
        end else if (o_w == ip_proto_pos) begin
          st_upd.ip_proto = beat.data_byte;
        end else if (o_w > ip_proto_pos) begin
          if (o_w == tcp_pos) begin
            st_upd.src_port = {beat.data_byte, 8'd0};
          end else if (o_w == tcp_pos + CW'(1)) begin
            st_upd.src_port = {st_cur.src_port[15:8], beat.data_byte};
          end else if (o_w == tcp_pos + CW'(TCP_DPORT_HI_OFF)) begin
            st_upd.dst_port = {beat.data_byte, 8'd0};
          end else if (o_w == tcp_pos + CW'(TCP_DPORT_HI_OFF) + CW'(1)) begin
            st_upd.dst_port = {st_cur.dst_port[15:8], beat.data_byte};
          end else if (o_w == tcp_pos + CW'(TCP_DOFF_OFF)) begin
            st_upd.tcp_end = st_cur.tcp_start + 8'({beat.data_byte[7:4], 2'b00});
          end
        end
      end
      default: st_upd = st_cur;
    endcase

    // Count bytes, holding at the top value
    off_inc = (&off_cur) ? off_cur : off_cur + OFFSET_WIDTH'(1);
    len_w   = CW'(off_inc);

    hit = (st_upd.status == HDR_IP)
       && (st_upd.ip_proto == PROTO_TCP)
       && (beat.packet_color == 8'd0 || beat.packet_color == cfg.tracked_color)
       && (len_w >= CW'(st_upd.tcp_start) + CW'(TCP_MIN_LEN))
       && (len_w > CW'(st_upd.tcp_end))
       && (st_upd.src_port == cfg.match_port || st_upd.dst_port == cfg.match_port);

    verdict.matched   = hit;
    verdict.color_out = hit ? cfg.tracked_color : beat.packet_color;

    // Clear after the last byte of a frame
    off_nxt = beat.last_byte ? '0 : off_inc;
    st_nxt  = beat.last_byte ? HDR_CLEAR : st_upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r <= '0;
      st_r  <= HDR_CLEAR;
    end else if (step) begin
      off_r <= off_nxt;
      st_r  <= st_nxt;
    end
  end

endmodule

/* rtl/tcp_port_packet_classifier_unit.sv */
// Top level of the TCP port packet classifier.
//
//   channel  dir  beat contents                                   handshake
//   in_ch    in   data_byte, first_byte, last_byte, packet_color  valid/ready
//   out_ch   out  matched, color_out (one beat per frame)         valid/ready
//   cfg_*    in   cfg_index, cfg_wdata                            cfg_we
//
// One beat a cycle but for the wait below: an input register feeds the parser,
// whose verdict is loaded into an output register as the last byte advances.
// Non-final bytes never wait on the output side; a last byte waits in the
// input register only while the output register holds an untaken verdict.
// Synchronous active-low reset clears the handshake state and frame parser.
module tcp_port_packet_classifier_unit
  import tpc_pkg::*;
#(
  parameter int OFFSET_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  tpc_in_if.sink                in_ch,
  tpc_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t     cfg;
  verdict_t verdict;
  beat_t    s1_beat_r;
  logic     s1_valid_r, s1_valid_nxt;
  verdict_t out_r;
  logic     out_valid_r, out_valid_nxt;
  logic     out_free, s1_go, in_fire, emit;

  tpc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tpc_parser #(
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (s1_go),
    .beat    (s1_beat_r),
    .cfg     (cfg),
    .verdict (verdict)
  );

  // Advance the input register when the verdict has a place to go
  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_go       = s1_valid_r && (!s1_beat_r.last_byte || out_free);
  assign emit        = s1_go && s1_beat_r.last_byte;
  assign in_ch.ready = !s1_valid_r || s1_go;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt = in_fire ? 1'b1 : (s1_go ? 1'b0 : s1_valid_r);
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Handshake state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_beat_r.data_byte    <= in_ch.data_byte;
      s1_beat_r.first_byte   <= in_ch.first_byte;
      s1_beat_r.last_byte    <= in_ch.last_byte;
      s1_beat_r.packet_color <= in_ch.packet_color;
    end
    if (emit) begin
      out_r <= verdict;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.matched   = out_r.matched;
  assign out_ch.color_out = out_r.color_out;

endmodule

/* rtl/tpc_checker.sv */
// Port-level assertions for the classifier, bound to the top level.
module tpc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_first,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_matched,
  input logic [7:0] out_color
);

  // Hold a stalled verdict beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("verdict beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_matched) && $stable(out_color))
    else $error("verdict payload changed while stalled");

  // A last byte reaches the output once the output side is free
  a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last) ##1 (!out_valid || out_ready) |=> out_valid)
    else $error("last byte produced no verdict");

  // A one-byte frame never matches
  a_short_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_first && in_last) ##1 (!out_valid || out_ready)
      |=> !out_matched)
    else $error("one-byte frame matched");

endmodule

bind tcp_port_packet_classifier_unit tpc_checker u_tpc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_first    (in_ch.first_byte),
  .in_last     (in_ch.last_byte),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_matched (out_ch.matched),
  .out_color   (out_ch.color_out)
);

/* verif/tcp_port_packet_classifier_unit_tb.sv */
// Self-checking testbench for the TCP port packet classifier unit.
module tcp_port_packet_classifier_unit_tb
  import tpc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CFG_UNUSED = 2'd3;  // index past the last register
  localparam int LONG_STALL = 300;
  localparam int SETTLE = 8;
  localparam int LIMIT_NS = 5_000_000;

  typedef enum {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_t;
  typedef enum {CUT_FULL, CUT_AT_END, CUT_BEFORE_DOFF, CUT_AT_DOFF, CUT_SHORT} cut_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tpc_in_if in_ch ();
  tpc_out_if out_ch ();

  tcp_port_packet_classifier_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Beats waiting to be driven and verdicts waiting to come out
  beat_t    beat_q[$];
  verdict_t verdict_q[$];
  beat_t    drv_beat;

  int n_pushed;     // beats queued by the stimulus
  int n_taken;      // beats accepted by the block
  int n_open;       // verdicts predicted but not yet seen
  int n_sent_res;   // last-byte beats queued
  int n_err;
  int src_pct;
  int snk_pct;
  int stall_req;
  int stall_seen;
  int stall_left;
  bit need_first;

  // Register values as the stimulus aims them
  logic [7:0]  aim_color;
  logic [15:0] aim_mpls;
  logic [15:0] aim_port;

  // Classifier state of the prediction
  logic [7:0]  trk_color;
  logic [15:0] mpls_type;
  logic [15:0] port_sel;
  hdr_state_t  fs;
  logic [15:0] frame_pos;

  // Predict the verdict, if any, caused by one accepted beat
  task automatic classify_beat(input beat_t bt, output bit done, output verdict_t v);
    int o;
    int len;
    logic [7:0] b;
    bit hit;
    b = bt.data_byte;
    done = 1'b0;
    v = '0;
    if (bt.first_byte) begin
      fs = HDR_CLEAR;
      frame_pos = '0;
    end
    o = frame_pos;
    case (fs.status)
      HDR_ETH: begin
        if (o == ETYPE_HI_OFF || o == VLAN_ETYPE_HI_OFF) begin
          fs.ether_kind = {b, 8'h00};
        end else if (o == ETYPE_LO_OFF || o == VLAN_ETYPE_LO_OFF) begin
          fs.ether_kind[7:0] = b;
          // the tag check wins over the label check, the label over IPv4
          if (o == ETYPE_LO_OFF && fs.ether_kind == ETH_VLAN) begin
            fs.has_vlan = 1'b1;
          end else if (o == ETYPE_LO_OFF || fs.has_vlan) begin
            fs.ip_start = fs.has_vlan ? VLAN_HDR_LEN : ETH_HDR_LEN;
            if (fs.ether_kind == mpls_type) begin
              fs.ip_start = fs.ip_start + MPLS_LABEL_LEN;
              fs.status = HDR_IP;
            end else if (fs.ether_kind == ETH_IPV4) begin
              fs.status = HDR_IP;
            end else begin
              fs.status = HDR_REJECT;
            end
          end
        end
      end
      HDR_IP: begin
        if (o == fs.ip_start) begin
          if (b[3:0] < IHL_MIN) fs.status = HDR_REJECT;
          else fs.tcp_start = fs.ip_start + {2'b00, b[3:0], 2'b00};
        end else if (o == fs.ip_start + IP_PROTO_OFF) begin
          fs.ip_proto = b;
        end else if (o > fs.ip_start + IP_PROTO_OFF) begin
          if (o == fs.tcp_start) fs.src_port = {b, 8'h00};
          else if (o == fs.tcp_start + 1) fs.src_port[7:0] = b;
          else if (o == fs.tcp_start + TCP_DPORT_HI_OFF) fs.dst_port = {b, 8'h00};
          else if (o == fs.tcp_start + TCP_DPORT_HI_OFF + 1) fs.dst_port[7:0] = b;
          else if (o == fs.tcp_start + TCP_DOFF_OFF)
            fs.tcp_end = fs.tcp_start + {2'b00, b[7:4], 2'b00};
        end
      end
      default: ;
    endcase
    if (frame_pos != '1) frame_pos = frame_pos + 1'b1;
    if (bt.last_byte) begin
      len = frame_pos;
      hit = fs.status == HDR_IP && fs.ip_proto == PROTO_TCP
        && (bt.packet_color == 8'd0 || bt.packet_color == trk_color)
        && len >= fs.tcp_start + TCP_MIN_LEN && len > fs.tcp_end
        && (fs.src_port == port_sel || fs.dst_port == port_sel);
      v.matched = hit;
      v.color_out = hit ? trk_color : bt.packet_color;
      done = 1'b1;
      fs = HDR_CLEAR;
      frame_pos = '0;
    end
  endtask

  task automatic report(input string msg);
    n_err++;
    if (n_err <= 10) $display("%s", msg);
  endtask

  // Drive input beats from the queue, idling at random
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (beat_q.size() > 0 && $urandom_range(99) >= src_pct) begin
        drv_beat = beat_q.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= drv_beat.data_byte;
        in_ch.first_byte <= drv_beat.first_byte;
        in_ch.last_byte <= drv_beat.last_byte;
        in_ch.packet_color <= drv_beat.packet_color;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Accept verdicts, stalling at random or for a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (stall_seen != stall_req) begin
      stall_seen = stall_req;
      stall_left = LONG_STALL;
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= snk_pct);
    end
  end

  // Check verdicts, predict from accepted beats, track register writes
  bit       mon_done;
  verdict_t mon_v;
  verdict_t want;
  always @(posedge clk) begin
    if (!rst_n) begin
      trk_color = TRACKED_COLOR_RST;
      mpls_type = MPLS_ETHERTYPE_RST;
      port_sel = MATCH_PORT_RST;
      fs = HDR_CLEAR;
      frame_pos = '0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (verdict_q.size() == 0) begin
          report($sformatf("unexpected verdict: matched %0b color %0h",
                           out_ch.matched, out_ch.color_out));
        end else begin
          want = verdict_q.pop_front();
          n_open--;
          if (out_ch.matched !== want.matched)
            report($sformatf("matched: expected %0b, got %0b", want.matched, out_ch.matched));
          if (out_ch.color_out !== want.color_out)
            report($sformatf("color_out: expected %0h, got %0h",
                             want.color_out, out_ch.color_out));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        n_taken++;
        classify_beat({in_ch.data_byte, in_ch.first_byte, in_ch.last_byte,
                       in_ch.packet_color}, mon_done, mon_v);
        if (mon_done) begin
          verdict_q.push_back(mon_v);
          n_open++;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_TRACKED_COLOR:  trk_color = cfg_wdata[7:0];
          CFG_MPLS_ETHERTYPE: mpls_type = cfg_wdata;
          CFG_MATCH_PORT:     port_sel = cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  task automatic set_idle(input idle_mode_t m);
    src_pct = (m == IDLE_SRC) ? 55 : (m == IDLE_BOTH) ? 31 : 0;
    snk_pct = (m == IDLE_SNK) ? 55 : (m == IDLE_BOTH) ? 31 : 0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    case (idx)
      CFG_TRACKED_COLOR:  aim_color = val[7:0];
      CFG_MPLS_ETHERTYPE: aim_mpls = val;
      CFG_MATCH_PORT:     aim_port = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold until every beat is taken and every verdict is back
  task automatic drain();
    wait (n_taken == n_pushed && n_open == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic put_beat(input logic [7:0] d, input bit f, input bit l, input logic [7:0] c);
    beat_t bt;
    bt.data_byte = d;
    bt.first_byte = f;
    bt.last_byte = l;
    bt.packet_color = c;
    beat_q.push_back(bt);
    n_pushed++;
    if (l) n_sent_res++;
  endtask

  function automatic logic [7:0] pick_color();
    case ($urandom_range(4))
      0, 1:    return 8'd0;
      2, 3:    return aim_color;
      default: return 8'($urandom);
    endcase
  endfunction

  // Queue one Ethernet/TCP frame, cut at the chosen point
  task automatic tcp_frame(input bit vlan, input logic [15:0] etype, input logic [3:0] ihl,
                           input logic [7:0] proto, input logic [15:0] sp,
                           input logic [15:0] dp, input logic [3:0] doff, input cut_t cut,
                           input int pay, input logic [7:0] color);
    logic [7:0] frm[$];
    int ip_pos;
    int tcp_pos;
    int hdr_end;
    int flen;
    bit mark;
    if (!vlan && etype == ETH_VLAN) etype = ETH_IPV4;
    repeat (12) frm.push_back(8'($urandom));
    if (vlan) begin
      frm.push_back(ETH_VLAN[15:8]);
      frm.push_back(ETH_VLAN[7:0]);
      repeat (2) frm.push_back(8'($urandom));
    end
    frm.push_back(etype[15:8]);
    frm.push_back(etype[7:0]);
    if (etype == aim_mpls) repeat (4) frm.push_back(8'($urandom));
    ip_pos = frm.size();
    frm.push_back({4'h4, ihl});
    repeat (8) frm.push_back(8'($urandom));
    frm.push_back(proto);
    while (frm.size() < ip_pos + 4 * ((ihl < IHL_MIN) ? 5 : int'(ihl)))
      frm.push_back(8'($urandom));
    tcp_pos = frm.size();
    frm.push_back(sp[15:8]);
    frm.push_back(sp[7:0]);
    frm.push_back(dp[15:8]);
    frm.push_back(dp[7:0]);
    repeat (8) frm.push_back(8'($urandom));
    frm.push_back({doff, 4'($urandom)});
    hdr_end = tcp_pos + ((int'(doff) * 4 > 13) ? int'(doff) * 4 : 13);
    case (cut)
      CUT_FULL:        flen = hdr_end + pay;
      CUT_AT_END:      flen = tcp_pos + int'(doff) * 4;
      CUT_BEFORE_DOFF: flen = tcp_pos + 12;
      CUT_AT_DOFF:     flen = tcp_pos + 13;
      default:         flen = $urandom_range(tcp_pos + 12, 1);
    endcase
    while (frm.size() < flen) frm.push_back(8'($urandom));
    // leave the start mark off now and then: a frame also begins after a last byte
    mark = need_first || ($urandom_range(4) != 0);
    need_first = 1'b0;
    for (int i = 0; i < flen; i++)
      put_beat(frm[i], mark && i == 0, i == flen - 1,
               (i == flen - 1) ? color : 8'($urandom));
  endtask

  // Random bytes with random frame marks, closed by a last byte
  task automatic noise(input int n);
    for (int i = 0; i < n; i++)
      put_beat(8'($urandom), $urandom_range(9) == 0, i == n - 1 || $urandom_range(6) == 0,
               pick_color());
  endtask

  // Unterminated bytes; the next frame must restart with a start mark
  task automatic junk(input int n);
    repeat (n) put_beat(8'($urandom), 1'b0, 1'b0, 8'($urandom));
    need_first = 1'b1;
  endtask

  task automatic rand_frame();
    bit vlan;
    logic [15:0] et;
    logic [15:0] sp;
    logic [15:0] dp;
    logic [3:0] ihl;
    logic [3:0] doff;
    logic [7:0] proto;
    cut_t cut;
    int r;
    vlan = ($urandom_range(3) == 0);
    r = $urandom_range(9);
    if (r < 5) et = ETH_IPV4;
    else if (r < 7) et = aim_mpls;
    else if (r == 7) et = ETH_VLAN;
    else et = 16'($urandom);
    ihl = ($urandom_range(4) != 0) ? 4'd5 : 4'($urandom);
    proto = ($urandom_range(6) != 0) ? PROTO_TCP : 8'($urandom);
    doff = ($urandom_range(3) != 0) ? 4'd5 : 4'($urandom);
    sp = 16'($urandom);
    dp = 16'($urandom);
    case ($urandom_range(3))
      0: sp = aim_port;
      1: dp = aim_port;
      2: begin
        sp = aim_port;
        dp = aim_port;
      end
      default: ;
    endcase
    r = $urandom_range(9);
    cut = (r < 6) ? CUT_FULL : (r == 6) ? CUT_AT_END : (r == 7) ? CUT_BEFORE_DOFF :
          (r == 8) ? CUT_AT_DOFF : CUT_SHORT;
    tcp_frame(vlan, et, ihl, proto, sp, dp, doff, cut, $urandom_range(24, 1), pick_color());
  endtask

  // Mostly well-formed frames, some noise, until enough beats and verdicts
  task automatic random_burst();
    int b0;
    int r0;
    b0 = n_pushed;
    r0 = n_sent_res;
    while (n_pushed - b0 < 24 || n_sent_res - r0 < 1) begin
      if ($urandom_range(3) == 0) noise($urandom_range(16, 1));
      else rand_frame();
    end
  endtask

  initial begin
    int ph;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.first_byte = 1'b0;
    in_ch.last_byte = 1'b0;
    in_ch.packet_color = '0;
    out_ch.ready = 1'b0;
    aim_color = TRACKED_COLOR_RST;
    aim_mpls = MPLS_ETHERTYPE_RST;
    aim_port = MATCH_PORT_RST;
    set_idle(IDLE_NONE);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed frames under the reset register values
    tcp_frame(0, ETH_IPV4, 5, PROTO_TCP, aim_port, 16'd80, 5, CUT_FULL, 4, 8'd0);
    tcp_frame(0, ETH_IPV4, 5, PROTO_TCP, 16'd443, aim_port, 5, CUT_FULL, 4, aim_color);
    tcp_frame(0, ETH_IPV4, 5, PROTO_TCP, aim_port, aim_port, 5, CUT_FULL, 1, 8'd2);
    tcp_frame(0, ETH_IPV4, 5, 8'd17, aim_port, 16'd80, 5, CUT_FULL, 4, 8'd0);
    tcp_frame(1, ETH_IPV4, 5, PROTO_TCP, aim_port, 16'd0, 5, CUT_FULL, 4, 8'd0);
    tcp_frame(0, aim_mpls, 5, PROTO_TCP, 16'hFFFF, aim_port, 5, CUT_FULL, 4, 8'd0);
    tcp_frame(1, aim_mpls, 5, PROTO_TCP, aim_port, 16'd0, 5, CUT_FULL, 4, aim_color);
    tcp_frame(1, ETH_VLAN, 5, PROTO_TCP, aim_port, aim_port, 5, CUT_FULL, 4, 8'd0);
    tcp_frame(0, 16'h86DD, 5, PROTO_TCP, aim_port, aim_port, 5, CUT_FULL, 4, 8'd0);
    tcp_frame(0, ETH_IPV4, 4, PROTO_TCP, aim_port, aim_port, 5, CUT_FULL, 4, 8'd0);
    tcp_frame(0, ETH_IPV4, 15, PROTO_TCP, aim_port, 16'd0, 15, CUT_FULL, 2, 8'd0);
    tcp_frame(0, ETH_IPV4, 5, PROTO_TCP, aim_port, 16'd0, 0, CUT_FULL, 1, 8'd0);
    tcp_frame(0, ETH_IPV4, 5, PROTO_TCP, aim_port, 16'd0, 3, CUT_AT_DOFF, 0, 8'd0);
    tcp_frame(0, ETH_IPV4, 5, PROTO_TCP, aim_port, 16'd0, 5, CUT_AT_END, 0, 8'd0);
    tcp_frame(0, ETH_IPV4, 5, PROTO_TCP, aim_port, 16'd0, 5, CUT_BEFORE_DOFF, 0, 8'd0);
    tcp_frame(0, ETH_IPV4, 5, PROTO_TCP, aim_port, 16'd0, 5, CUT_SHORT, 0, 8'd0);
    put_beat(8'hFF, 1'b1, 1'b1, 8'hFF);
    junk(5);
    tcp_frame(0, ETH_IPV4, 5, PROTO_TCP, 16'd0, aim_port, 5, CUT_FULL, 3, 8'd0);
    drain();

    // Random phases, each under its own register setting and idle pattern
    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_TRACKED_COLOR, {8'($urandom), 8'hFF});
          write_reg(CFG_MPLS_ETHERTYPE, 16'hFFFF);
          write_reg(CFG_MATCH_PORT, 16'h0000);
          set_idle(IDLE_SRC);
        end
        1: begin
          write_reg(CFG_TRACKED_COLOR, 16'h0000);
          write_reg(CFG_MPLS_ETHERTYPE, ETH_VLAN);
          write_reg(CFG_MATCH_PORT, 16'hFFFF);
          write_reg(CFG_UNUSED, 16'($urandom));
          set_idle(IDLE_SNK);
          // long hold-off on the verdict side while beats keep coming
          stall_req++;
          repeat (10) noise($urandom_range(6, 1));
        end
        2: begin
          write_reg(CFG_TRACKED_COLOR, 16'($urandom));
          write_reg(CFG_MPLS_ETHERTYPE, ETH_IPV4);
          write_reg(CFG_MATCH_PORT, 16'($urandom));
          set_idle(IDLE_BOTH);
        end
        3: begin
          write_reg(CFG_TRACKED_COLOR, TRACKED_COLOR_RST);
          write_reg(CFG_MPLS_ETHERTYPE, 16'h0000);
          write_reg(CFG_MATCH_PORT, 16'd443);
          set_idle(IDLE_NONE);
        end
        default: begin
          write_reg(CFG_UNUSED, 16'($urandom));
          write_reg(CFG_TRACKED_COLOR, 16'($urandom));
          write_reg(CFG_MPLS_ETHERTYPE, 16'($urandom));
          write_reg(CFG_MATCH_PORT, 16'($urandom));
          set_idle(IDLE_SRC);
          random_burst();
          set_idle(IDLE_NONE);
        end
      endcase
      random_burst();
      drain();
    end

    if (n_err == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("Verification failed");
    $finish;
  end

endmodule
